// File: rtl/spectrum_band_envelope_assert.svh
// Assertion macros for the band envelope block.
// Included by the top level; no other dependencies.
`ifndef SPECTRUM_BAND_ENVELOPE_ASSERT_SVH
`define SPECTRUM_BAND_ENVELOPE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SBE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SBE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SBE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/sbe_pkg.sv
// Package for the band envelope block: types, constants, state codes.
// No dependencies.
package sbe_pkg;
   localparam int BAND_COUNT_DEF    = 64;
   localparam int HISTORY_DEPTH_DEF = 32;
   localparam int LEVEL_BITS_DEF    = 16;
   localparam int BAND_W  = 6;
   localparam int DATA_W  = 16;
   localparam int CSR_AW  = 4;

   localparam logic [15:0] ATTACK_RST  = 16'd52429;
   localparam logic [15:0] RELEASE_RST = 16'd7864;
   localparam logic [15:0] DECAY_RST   = 16'd58982;
   localparam logic [15:0] FLOOR_RST   = 16'd45875;

   localparam logic [CSR_AW-1:0] ADDR_ATTACK  = 4'h0;
   localparam logic [CSR_AW-1:0] ADDR_RELEASE = 4'h4;
   localparam logic [CSR_AW-1:0] ADDR_DECAY   = 4'h8;
   localparam logic [CSR_AW-1:0] ADDR_FLOOR   = 4'hC;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRITE, ST_SCAN, ST_SCAN_LAST, ST_DIV,
      ST_MUL_A, ST_MUL_B, ST_PEAK, ST_FLOOR, ST_DONE, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;
endpackage

// File: rtl/sbe_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface sbe_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/spectrum_band_envelope.sv
// Band envelope top level: CSR port, history memory, sequencer, shared multiplier.
// Depends on sbe_pkg, sbe_if, sbe_div and spectrum_band_envelope_assert.svh.
// Sequence: rsp_valid rises after the request transaction has passed through the write,
// scan, divider load and divide steps and five blend/peak steps. One item at a time: a
// new request is accepted only once the last response has been taken with rsp_ready high.
// After reset a clearing pass over all 2^(band bits + history bits) history entries
// (2048) zeroes all state before the first request.
`include "spectrum_band_envelope_assert.svh"
module spectrum_band_envelope #(
   parameter int BAND_COUNT    = sbe_pkg::BAND_COUNT_DEF,
   parameter int HISTORY_DEPTH = sbe_pkg::HISTORY_DEPTH_DEF,
   parameter int LEVEL_BITS    = sbe_pkg::LEVEL_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   sbe_if.sink                        req,
   sbe_if.source                      rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [sbe_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import sbe_pkg::*;
   localparam int BIW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
   localparam int HIW = $clog2(HISTORY_DEPTH);
   localparam int BSZ = 1 << BIW;
   localparam int MAW = BIW + HIW;
   localparam int MD  = 1 << MAW;
   localparam int LW  = LEVEL_BITS;
   localparam int NW  = 16 + LW;
   localparam logic [LW-1:0] LMAX = {LW{1'b1}};
   // band modulo by reciprocal multiplication, exact for 6-bit bands
   localparam int RS  = 14;
   localparam int RM  = ((1 << RS) + BAND_COUNT - 1) / BAND_COUNT;

   function automatic logic [BIW-1:0] band_index(input logic [BAND_W-1:0] b);
      logic [BAND_W+RS-1:0] prod;
      logic [BAND_W+RS-1:0] quo;
      logic [BAND_W+RS-1:0] rem;
      prod = {{RS{1'b0}}, b} * (BAND_W+RS)'(RM);
      quo  = prod >> RS;
      rem  = {{RS{1'b0}}, b} - quo * (BAND_W+RS)'(BAND_COUNT);
      return rem[BIW-1:0];
   endfunction

   // CSR
   logic [15:0] attack_ff, release_ff, decay_ff, floor_ff;
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= ATTACK_RST;
         release_ff <= RELEASE_RST;
         decay_ff   <= DECAY_RST;
         floor_ff   <= FLOOR_RST;
      end else if (csr_wr) begin
         case (csr_paddr)
            ADDR_ATTACK:  attack_ff  <= csr_pwdata[15:0];
            ADDR_RELEASE: release_ff <= csr_pwdata[15:0];
            ADDR_DECAY:   decay_ff   <= csr_pwdata[15:0];
            ADDR_FLOOR:   floor_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr)
         ADDR_ATTACK:  csr_prdata = {16'd0, attack_ff};
         ADDR_RELEASE: csr_prdata = {16'd0, release_ff};
         ADDR_DECAY:   csr_prdata = {16'd0, decay_ff};
         ADDR_FLOOR:   csr_prdata = {16'd0, floor_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // per-band state memory, registered read at the current band
   logic [HIW-1:0] pos_mem [BSZ];
   logic [LW-1:0]  lvl_mem [BSZ];
   logic [LW-1:0]  pk_mem  [BSZ];
   logic           bs_we;
   logic [BIW-1:0] bs_waddr, bs_raddr;
   logic [HIW-1:0] bs_pos_wr, bs_pos_rd;
   logic [LW-1:0]  bs_lvl_wr, bs_lvl_rd, bs_pk_wr, bs_pk_rd;
   logic [LW-1:0]  fmax_ff;
   always_ff @(posedge clock) begin
      if (bs_we) begin
         pos_mem[bs_waddr] <= bs_pos_wr;
         lvl_mem[bs_waddr] <= bs_lvl_wr;
         pk_mem[bs_waddr]  <= bs_pk_wr;
      end
      bs_pos_rd <= pos_mem[bs_raddr];
      bs_lvl_rd <= lvl_mem[bs_raddr];
      bs_pk_rd  <= pk_mem[bs_raddr];
   end

   // history memory
   logic [15:0]    hist_mem [MD];
   logic           mem_we;
   logic [MAW-1:0] mem_waddr, mem_raddr;
   logic [15:0]    mem_wdata, mem_rdata;
   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
      mem_rdata <= hist_mem[mem_raddr];
   end

   state_type st_ff, st_in;
   logic [MAW-1:0] clr_ff, clr_in;
   logic [BAND_W-1:0] braw_ff, braw_in;
   logic [15:0] en_ff, en_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [HIW:0] idx_ff, idx_in;
   logic [LW-1:0] norm_ff, norm_in, lv_ff, lv_in, pk_r_ff, pk_r_in, fm_in;
   logic [LW+16:0] acc_ff, acc_in;
   logic [BIW-1:0] bidx;
   logic div_start;
   div_ctrl_type div_ctrl;
   logic [NW-1:0] quot, div_num;
   logic [15:0] rng;
   logic [15:0] mul_a;
   logic [LW-1:0] mul_b;
   logic [LW+15:0] mul_p;
   logic [LW+16:0] blend;
   logic [15:0] gain;
   logic out_valid_ff, out_valid_in;
   logic [LW-1:0] fl;

   assign bidx = band_index(braw_ff);
   assign mul_p = mul_a * mul_b;   // the one shared multiplier
   assign rng = (hi_ff == lo_ff) ? 16'd1 : (hi_ff - lo_ff);
   assign div_num = NW'(en_ff - lo_ff) << LW;
   assign gain = (norm_ff > lv_ff) ? attack_ff : release_ff;

   sbe_div #(.NW(NW), .DW(16)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(rng), .ctrl(div_ctrl), .quot(quot)
   );

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      braw_in = braw_ff;
      en_in = en_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      idx_in = idx_ff;
      norm_in = norm_ff;
      lv_in = lv_ff;
      pk_r_in = pk_r_ff;
      acc_in = acc_ff;
      fm_in = fmax_ff;
      out_valid_in = out_valid_ff;
      mem_we = 1'b0;
      mem_waddr = MAW'({bidx, bs_pos_rd});
      mem_wdata = en_ff;
      mem_raddr = MAW'({bidx, idx_ff[HIW-1:0]});
      bs_we = 1'b0;
      bs_waddr = bidx;
      bs_raddr = bidx;
      bs_pos_wr = (bs_pos_rd == HIW'(HISTORY_DEPTH - 1)) ? '0 : bs_pos_rd + 1'b1;
      bs_lvl_wr = lv_ff;
      bs_pk_wr = pk_r_ff;
      div_start = 1'b0;
      mul_a = gain;
      mul_b = norm_ff;
      blend = '0;
      fl = '0;
      req.ready = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            bs_we = 1'b1;
            bs_waddr = clr_ff[BIW-1:0];
            bs_pos_wr = '0;
            bs_lvl_wr = '0;
            bs_pk_wr = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MAW'(MD - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req.ready = ~out_valid_ff;
            // band state read ahead so it is ready in the write step
            bs_raddr = band_index(req.data[BAND_W+15:16]);
            if (req.valid && !out_valid_ff) begin
               braw_in = req.data[BAND_W+15:16];
               en_in = req.data[15:0];
               st_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            lo_in = en_ff;
            hi_in = en_ff;
            idx_in = '0;
            mem_raddr = MAW'({bidx, {HIW{1'b0}}});
            idx_in = (HIW+1)'(1);
            st_in = ST_SCAN;
         end
         ST_SCAN: begin
            // rdata holds entry idx-1; the slot just written may read stale, so
            // skip it and use en_ff in its place (already seeded)
            if (idx_ff - 1'b1 != {1'b0, bs_pos_rd}) begin
               if (mem_rdata < lo_ff) lo_in = mem_rdata;
               if (mem_rdata > hi_ff) hi_in = mem_rdata;
            end
            if (idx_ff == (HIW+1)'(HISTORY_DEPTH)) begin
               st_in = ST_SCAN_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN_LAST: begin
            // last entry now folded into lo/hi
            div_start = 1'b1;
            st_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_ctrl.busy && !div_start && st_ff == ST_DIV) begin
               if (quot > NW'(LMAX)) norm_in = LMAX;
               else norm_in = quot[LW-1:0];
               lv_in = bs_lvl_rd;
               st_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            mul_a = gain;
            mul_b = norm_ff;
            acc_in = (LW+17)'(mul_p);
            st_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            mul_a = 16'(17'h10000 - {1'b0, gain});
            mul_b = lv_ff;
            // gain of zero makes 65536-gain overflow 16 bits: full weight on level
            if (gain == 16'd0) blend = acc_ff + (LW+17)'({lv_ff, 16'd0});
            else blend = acc_ff + (LW+17)'(mul_p);
            lv_in = (blend[LW+16:16] > (LW+1)'(LMAX)) ? LMAX : blend[LW+15:16];
            pk_r_in = bs_pk_rd;
            st_in = ST_PEAK;
         end
         ST_PEAK: begin
            mul_a = decay_ff;
            mul_b = pk_r_ff;
            if (lv_ff > pk_r_ff) pk_r_in = lv_ff;
            else pk_r_in = mul_p[LW+15:16];
            st_in = ST_FLOOR;
         end
         ST_FLOOR: begin
            mul_a = floor_ff;
            mul_b = pk_r_ff;
            fl = mul_p[LW+15:16];
            if (lv_ff < fl) lv_in = fl;
            st_in = ST_DONE;
         end
         ST_DONE: begin
            bs_we = 1'b1;
            if (braw_ff == '0) fm_in = lv_ff;
            else if (lv_ff > fmax_ff) fm_in = lv_ff;
            out_valid_in = 1'b1;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) begin
               out_valid_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
         fmax_ff <= '0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         out_valid_ff <= out_valid_in;
         fmax_ff <= fm_in;
      end
      braw_ff <= braw_in;
      en_ff <= en_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      idx_ff <= idx_in;
      norm_ff <= norm_in;
      lv_ff <= lv_in;
      pk_r_ff <= pk_r_in;
      acc_ff <= acc_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = {braw_ff, 16'(lv_ff), 16'(pk_r_ff), 16'(fmax_ff)};

   `SBE_ASSERT_IMPL(a_no_req_busy, clock, reset, st_ff != ST_IDLE, !req.ready)
   `SBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `SBE_ASSERT_IMPL(a_div_idle, clock, reset, st_ff == ST_IDLE, !div_ctrl.busy)
endmodule

// File: rtl/sbe_div.sv
// Restoring divider, one quotient bit a cycle.
// Depends on sbe_pkg.
module sbe_div #(
   parameter int NW = 32,
   parameter int DW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NW-1:0]        num,
   input  logic [DW-1:0]        den,
   output sbe_pkg::div_ctrl_type ctrl,
   output logic [NW-1:0]        quot
);
   import sbe_pkg::*;
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = (cnt_ff != '0);
   assign quot = q_ff;
endmodule
